// ===== hw/rtl/puct_child_select_macros.svh =====
// assertion macros for the child selection block
`ifndef PUCT_CHILD_SELECT_MACROS_SVH
`define PUCT_CHILD_SELECT_MACROS_SVH
`ifndef ASSERT_OFF
// checked outside reset
`define PCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/pcs_pkg.sv =====
package pcs_pkg;

    localparam int PRIOR_W     = 16;
    localparam int VISIT_W     = 20;
    localparam int VALUE_W     = 33;
    localparam int GAIN_W      = 16;
    localparam int SUM_W       = 28;
    localparam int ROOT_X_W    = 45;
    localparam int ROOT_W      = 23;
    localparam int ROOT_STEPS  = 23;
    localparam int CP_W        = PRIOR_W + GAIN_W;
    localparam int PROD_W      = CP_W + ROOT_W;
    localparam int PROD_SHIFT  = 20;
    localparam int DIVD_W      = 37;
    localparam int DIVS_W      = 21;
    localparam int Q_W         = DIVD_W + 1;
    localparam int SCORE_W     = Q_W + 1;
    localparam int ENTRY_W     = PRIOR_W + VISIT_W + VALUE_W;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 8;
    localparam int MAX_CHILDREN_DEF = 256;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
    localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};

    // register byte addresses
    localparam logic [2:0] ADDR_GAIN = 3'd0;

    // controller to datapath
    typedef struct packed {
        logic store;
        logic root_start;
        logic root_step;
        logic rd;
        logic mul1;
        logic mul2;
        logic div_start;
        logic div_sel_u;
        logic q_load;
        logic q_zero;
        logic u_load;
        logic cmp;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic root_done;
        logic div_done;
        logic v_zero;
        logic idx_last;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/pcs_div.sv =====
module pcs_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pcs_pkg::DIVD_W-1:0] dividend,
    input  logic [pcs_pkg::DIVS_W-1:0] divisor,
    output logic                       done,
    output logic [pcs_pkg::DIVD_W-1:0] quotient
);
    import pcs_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dsr_reg;
    logic [DIVS_W:0]   trial;
    logic              fits;

    // one quotient bit a cycle, restoring
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DIVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            if (fits)
                rem_reg <= DIVS_W'(trial - {1'b0, dsr_reg});
            else
                rem_reg <= trial[DIVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/pcs_datapath.sv =====
`include "puct_child_select_macros.svh"
module pcs_datapath #(
    parameter int MAX_CHILDREN = pcs_pkg::MAX_CHILDREN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pcs_pkg::cmd_t               cmd,
    output pcs_pkg::status_t            st,
    input  logic [pcs_pkg::GAIN_W-1:0]  gain,
    input  logic [pcs_pkg::PRIOR_W-1:0] prior,
    input  logic [pcs_pkg::VISIT_W-1:0] visit_count,
    input  logic [pcs_pkg::VALUE_W-1:0] acc_value,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [7:0]                  best_index,
    output logic                        overflow
);
    import pcs_pkg::*;

    localparam int AW = $clog2(MAX_CHILDREN);
    localparam int CW = $clog2(MAX_CHILDREN + 1);
    localparam int IW = (AW > 8) ? AW : 8;
    localparam int RC_W = $clog2(ROOT_STEPS);

    // child store
    logic [ENTRY_W-1:0] mem [MAX_CHILDREN];
    logic [ENTRY_W-1:0] rd_reg;

    logic [CW-1:0]    count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             ovf_reg;
    logic [SUM_W:0]   sum_add;
    logic             has_room;

    logic [ROOT_X_W-1:0] rx_reg;
    logic [ROOT_X_W-1:0] rres_reg;
    logic [ROOT_X_W-1:0] rbit_reg;
    logic [ROOT_X_W-1:0] rtrial;
    logic [RC_W-1:0]     rcnt_reg;

    logic [AW-1:0]      idx_reg;
    logic [CP_W-1:0]    cp_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [Q_W-1:0]     q_reg;
    logic [DIVD_W-1:0]  u_reg;
    logic [SCORE_W-1:0] best_score_reg;
    logic [AW-1:0]      best_idx_reg;
    logic [SCORE_W-1:0] score;

    logic              out_valid_reg;
    logic [7:0]        out_idx_reg;
    logic              out_ovf_reg;
    logic [IW-1:0]     best_ext;

    logic [PRIOR_W-1:0] rd_prior;
    logic [VISIT_W-1:0] rd_visit;
    logic [VALUE_W-1:0] rd_value;
    logic [VALUE_W-1:0] mag;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic               div_done;
    logic [DIVD_W-1:0]  div_quo;

    assign rd_prior = rd_reg[PRIOR_W-1:0];
    assign rd_visit = rd_reg[PRIOR_W +: VISIT_W];
    assign rd_value = rd_reg[PRIOR_W+VISIT_W +: VALUE_W];

    assign has_room = count_reg < CW'(MAX_CHILDREN);
    assign sum_add  = {1'b0, sum_reg} + (SUM_W+1)'(visit_count);

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store && has_room)
            mem[count_reg[AW-1:0]] <= {acc_value, visit_count, prior};
        if (cmd.rd)
            rd_reg <= mem[idx_reg];
    end

    // node state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.store)
        begin
            if (has_room)
            begin
                count_reg <= count_reg + 1'b1;
                if (sum_add > {1'b0, SUM_MAX})
                    sum_reg <= SUM_MAX;
                else
                    sum_reg <= sum_add[SUM_W-1:0];
            end
            else
                ovf_reg <= 1'b1;
        end
    end

    // bit-pair square root of (sum + 1) << 16
    assign rtrial = rres_reg + rbit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rcnt_reg <= '0;
        else if (cmd.root_start)
            rcnt_reg <= '0;
        else if (cmd.root_step)
            rcnt_reg <= rcnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            rx_reg   <= {(SUM_W+1)'({1'b0, sum_reg} + (SUM_W+1)'(1)), 16'b0};
            rres_reg <= '0;
            rbit_reg <= ROOT_X_W'(1) << (ROOT_X_W - 1);
        end
        else if (cmd.root_step)
        begin
            if (rx_reg >= rtrial)
            begin
                rx_reg   <= rx_reg - rtrial;
                rres_reg <= (rres_reg >> 1) + rbit_reg;
            end
            else
                rres_reg <= rres_reg >> 1;
            rbit_reg <= rbit_reg >> 2;
        end
    end

    // shared divider operands
    assign mag = rd_value[VALUE_W-1] ? (~rd_value + 1'b1) : rd_value;

    always_comb
    begin
        if (cmd.div_sel_u)
        begin
            div_dividend = DIVD_W'(prod_reg[PROD_W-1:PROD_SHIFT]);
            div_divisor  = DIVS_W'(rd_visit) + DIVS_W'(1);
        end
        else
        begin
            div_dividend = {mag, 4'b0};
            div_divisor  = DIVS_W'(rd_visit);
        end
    end

    pcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // scoring pipeline
    assign score = {q_reg[Q_W-1], q_reg} + {2'b00, u_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
            cp_reg <= CP_W'(gain) * CP_W'(rd_prior);
        if (cmd.mul2)
            prod_reg <= PROD_W'(cp_reg) * PROD_W'(rres_reg[ROOT_W-1:0]);
        if (cmd.q_zero)
            q_reg <= '0;
        else if (cmd.q_load)
        begin
            if (rd_value[VALUE_W-1])
                q_reg <= {1'b0, div_quo};
            else
                q_reg <= Q_W'(-{1'b0, div_quo});
        end
        if (cmd.u_load)
            u_reg <= div_quo;
        if (cmd.cmp && ((idx_reg == '0) || ($signed(score) > $signed(best_score_reg))))
        begin
            best_score_reg <= score;
            best_idx_reg   <= idx_reg;
        end
    end

    // child index for the scoring pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.root_start)
            idx_reg <= '0;
        else if (cmd.cmp && !st.idx_last)
            idx_reg <= idx_reg + 1'b1;
    end

    // output register
    assign best_ext = IW'(best_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_idx_reg <= best_ext[7:0];
            out_ovf_reg <= ovf_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign best_index = out_idx_reg;
    assign overflow   = out_ovf_reg;

    // status
    assign st.root_done = rcnt_reg == RC_W'(ROOT_STEPS - 1);
    assign st.div_done  = div_done;
    assign st.v_zero    = rd_visit == '0;
    assign st.idx_last  = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign st.out_free  = !out_valid_reg || m_tready;

    `PCS_ASSERT(a_count_cap, clk, rst_n, count_reg <= CW'(MAX_CHILDREN), "child count past capacity")
    `PCS_ASSERT(a_idx_range, clk, rst_n, cmd.cmp |-> (CW'(idx_reg) < count_reg), "scored an unstored child")
    `PCS_ASSERT(a_node_clear, clk, rst_n, cmd.out_load |=> (count_reg == '0 && sum_reg == '0 && !ovf_reg), "node state not cleared")

endmodule

// ===== hw/rtl/pcs_ctrl.sv =====
module pcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  pcs_pkg::status_t  st,
    output pcs_pkg::cmd_t     cmd
);
    import pcs_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_ROOT_INIT = 12'b000000000010,
        S_ROOT      = 12'b000000000100,
        S_READ      = 12'b000000001000,
        S_MUL1      = 12'b000000010000,
        S_MUL2      = 12'b000000100000,
        S_DQ        = 12'b000001000000,
        S_DQ_WAIT   = 12'b000010000000,
        S_DU        = 12'b000100000000,
        S_DU_WAIT   = 12'b001000000000,
        S_CMP       = 12'b010000000000,
        S_DONE      = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencing of store, root and per-child scoring
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.store = 1'b1;
                    if (s_tlast)
                        state_next = S_ROOT_INIT;
                end
            end
            S_ROOT_INIT:
            begin
                cmd.root_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (st.root_done)
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_DQ;
            end
            S_DQ:
            begin
                if (st.v_zero)
                begin
                    cmd.q_zero = 1'b1;
                    state_next = S_DU;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DQ_WAIT;
                end
            end
            S_DQ_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.q_load = 1'b1;
                    state_next = S_DU;
                end
            end
            S_DU:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel_u = 1'b1;
                state_next    = S_DU_WAIT;
            end
            S_DU_WAIT:
            begin
                cmd.div_sel_u = 1'b1;
                if (st.div_done)
                begin
                    cmd.u_load = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (st.idx_last)
                    state_next = S_DONE;
                else
                    state_next = S_READ;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/puct_child_select.sv =====
// puct child selection for one search node
// s_* stream: one child per item, tlast marks the final child of the node.
// each child is stored as it is accepted; s_tready is high while the block waits
// for children. after the final child the block works out the root of
// (visit sum + 1), then scores every stored child in turn on one shared
// shift-subtract divider: per child a read, two multiplies, two 37-bit
// divisions and a compare; an unvisited child skips the first division.
// m_* stream: one item per node, tdata the best child index, tuser the
// overflow flag for children dropped beyond capacity. the result sits in an
// output register; the next node may be loaded while it waits, and a stalled
// receiver only holds back the following node's result.
// apb port: exploration gain at byte address 0, pready always high.
// reset clears the node state and the output valid and sets gain to 1.0;
// child stores are not cleared, only entries written for a node are read.
module puct_child_select #(
    parameter int MAX_CHILDREN = pcs_pkg::MAX_CHILDREN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // prior [15:0], visit_count [35:16], acc_value [68:36], zero fill
    input  logic [pcs_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // best_index [7:0]
    output logic [pcs_pkg::OUT_DATA_W-1:0] m_tdata,
    // overflow [0]
    output logic [0:0]                     m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import pcs_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    cmd_t              cmd;
    status_t           st;
    logic              ovf;

    // configuration register, word decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RESET;
        else if (psel && penable && pwrite && {paddr[2], 2'b00} == ADDR_GAIN)
            gain_reg <= pwdata[GAIN_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = ({paddr[2], 2'b00} == ADDR_GAIN) ? 32'(gain_reg) : 32'd0;

    pcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pcs_datapath #(
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .gain        (gain_reg),
        .prior       (s_tdata[PRIOR_W-1:0]),
        .visit_count (s_tdata[PRIOR_W +: VISIT_W]),
        .acc_value   (s_tdata[PRIOR_W+VISIT_W +: VALUE_W]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .best_index  (m_tdata),
        .overflow    (ovf)
    );

    assign m_tuser[0] = ovf;

endmodule
